// ===== design/lru_cache_hit_counter_top_assert.svh =====
// ----------------------------------------------------------------------------
// LRU cache hit counter assertion macros
// Shared property templates for the checker of the LRU cache hit counter.
// ----------------------------------------------------------------------------
`ifndef LRU_CACHE_HIT_COUNTER_TOP_ASSERT_SVH
`define LRU_CACHE_HIT_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("LRU cache hit counter assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("LRU cache hit counter assertion failed");

// Next-cycle implication that is also checked across reset.
`define LCC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("LRU cache hit counter assertion failed");

`endif

// ===== design/lcc_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU cache hit counter package
// Shared widths, reset values and the control struct sent to the cache entries.
// ----------------------------------------------------------------------------
`default_nettype none

package lcc_pkg;

  localparam int KEY_W           = 32;
  localparam int TALLY_W         = 32;
  localparam int CAP_W           = 5;
  localparam int MAX_ENTRIES_DEF = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic fire;
    logic hit;
    logic full;
  } lcc_ctl_t;

endpackage

`default_nettype wire

// ===== design/lcc_entry.sv =====
// ----------------------------------------------------------------------------
// LRU cache entry
// One cache line: key, valid bit and recency rank, with its own match and update.
// ----------------------------------------------------------------------------
`default_nettype none

module lcc_entry
  import lcc_pkg::*;
#(
  parameter int RANK_W = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lcc_ctl_t          ctl,
  input  wire logic [KEY_W-1:0]  key_i,
  input  wire logic [RANK_W-1:0] limit_i,
  input  wire logic [RANK_W-1:0] evict_rank_i,
  input  wire logic              free_sel_i,
  output logic                   match_o,
  output logic                   valid_o,
  output logic [RANK_W-1:0]      rank_o
);

  logic [KEY_W-1:0]  key_r;
  logic              valid_r;
  logic              valid_nxt;
  logic [RANK_W-1:0] rank_r;
  logic [RANK_W-1:0] rank_nxt;
  logic              evict_self;
  logic              wr;

  assign match_o    = valid_r && (key_r == key_i);
  assign valid_o    = valid_r;
  assign rank_o     = rank_r;
  assign evict_self = ctl.full && valid_r && (rank_r == evict_rank_i);
  assign wr         = ctl.fire && !ctl.hit && (ctl.full ? evict_self : free_sel_i);

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    if (ctl.fire) begin
      if (ctl.hit) begin
        if (match_o) begin
          rank_nxt = '0;
        end else if (valid_r && (rank_r < limit_i)) begin
          rank_nxt = rank_r + 1'b1;
        end
      end else if (wr) begin
        valid_nxt = 1'b1;
        rank_nxt  = '0;
      end else if (valid_r) begin
        rank_nxt = rank_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      key_r <= key_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/lcc_out_stage.sv =====
// ----------------------------------------------------------------------------
// LRU cache hit counter output stage
// Hit tally with saturation and the registered result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module lcc_out_stage
  import lcc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               ld_i,
  input  wire logic               hit_i,
  input  wire logic               last_i,
  input  wire logic               out_tready,
  output logic                    out_tvalid,
  output logic [TALLY_W-1:0]      out_tdata,
  output logic                    out_tuser,
  output logic                    out_tlast
);

  logic [TALLY_W-1:0] tally_r;
  logic [TALLY_W-1:0] tally_nxt;
  logic [TALLY_W-1:0] sum;
  logic               out_v_r;
  logic [TALLY_W-1:0] data_r;
  logic               hit_r;
  logic               last_r;

  assign sum = (hit_i && !(&tally_r)) ? tally_r + 1'b1 : tally_r;

  always_comb begin
    tally_nxt = tally_r;
    if (ld_i) begin
      tally_nxt = last_i ? '0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      tally_r <= tally_nxt;
      if (ld_i) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_i) begin
      data_r <= sum;
      hit_r  <= hit_i;
      last_r <= last_i;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = data_r;
  assign out_tuser  = hit_r;
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

// ===== design/lru_cache_hit_counter_top.sv =====
// ----------------------------------------------------------------------------
// LRU cache hit counter
// Fully associative LRU cache of 32-bit keys that reports hit or miss per key
// together with the running hit count of the current run.
//
// Keys arrive on the in_ stream (tdata = key, tlast = last key of a run). Each
// key is captured in an input register, looked up against all entries in
// parallel, and the cache state and result register are updated when the
// result register is free; the key thus passes the input register and then
// the result register before out_tvalid rises.
// One key per cycle is sustained while the receiver accepts results; compare,
// rank update and replacement select all happen in the same cycle.
// Results leave on the out_ stream: tdata = hit count of the run so far
// (saturating), tuser = hit, tlast = echo of the input tlast. The count clears
// after a result marked tlast. When the receiver stalls, the result is held
// and one further key may wait in the input register before in_tready drops.
// cfg_wen writes the capacity (1 to MAX_ENTRIES, other values are clamped).
// Reset empties the cache, clears the count and sets the capacity to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_cache_hit_counter_top
  import lcc_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [KEY_W-1:0]   in_tdata,   // [31:0] key
  input  wire logic               in_tlast,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TALLY_W-1:0]      out_tdata,  // [31:0] hits_so_far
  output logic                    out_tuser,  // [0] hit
  output logic                    out_tlast,
  input  wire logic               cfg_wen,
  input  wire logic [CAP_W-1:0]   cfg_wdata
);

  localparam int RANK_W = $clog2(MAX_ENTRIES);
  localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  logic               in_v_r;
  logic [KEY_W-1:0]   in_key_r;
  logic               in_last_r;
  logic               advance;
  logic [CAP_W-1:0]   cap_r;
  logic [OCC_W-1:0]   occ_r;
  logic [OCC_W-1:0]   occ_nxt;
  logic [CMP_W-1:0]   cap_eff;
  logic               full;
  logic               hit;
  logic [RANK_W-1:0]  hit_rank;
  logic [RANK_W-1:0]  evict_rank;
  logic [MAX_ENTRIES-1:0] match_vec;
  logic [MAX_ENTRIES-1:0] valid_vec;
  logic [MAX_ENTRIES-1:0] free_vec;
  logic [MAX_ENTRIES-1:0] free_oh;
  logic [RANK_W-1:0]  rank_arr [MAX_ENTRIES];
  lcc_ctl_t           ctl;

  assign advance   = in_v_r && (!out_tvalid || out_tready);
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      cap_r  <= CAP_RESET;
      occ_r  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (cfg_wen) begin
        cap_r <= cfg_wdata;
      end
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_key_r  <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  assign cap_eff    = (cap_r == '0) ? CMP_W'(1) : CMP_W'(cap_r);
  assign full       = (CMP_W'(occ_r) >= cap_eff) || (occ_r == OCC_W'(MAX_ENTRIES));
  assign evict_rank = RANK_W'(occ_r - OCC_W'(1));
  assign hit        = |match_vec;
  assign free_vec   = ~valid_vec;
  assign free_oh    = free_vec & (~free_vec + 1'b1);

  always_comb begin
    hit_rank = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_rank = hit_rank | (rank_arr[i] & {RANK_W{match_vec[i]}});
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (advance && !hit && !full) begin
      occ_nxt = occ_r + 1'b1;
    end
  end

  assign ctl = '{fire: advance, hit: hit, full: full};

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_entry
    lcc_entry #(
      .RANK_W (RANK_W)
    ) u_entry (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .key_i        (in_key_r),
      .limit_i      (hit_rank),
      .evict_rank_i (evict_rank),
      .free_sel_i   (free_oh[g]),
      .match_o      (match_vec[g]),
      .valid_o      (valid_vec[g]),
      .rank_o       (rank_arr[g])
    );
  end

  lcc_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld_i       (advance),
    .hit_i      (hit),
    .last_i     (in_last_r),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== design/lcc_checker.sv =====
// ----------------------------------------------------------------------------
// LRU cache hit counter checker
// Port-level assertions for the LRU cache hit counter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_cache_hit_counter_top_assert.svh"

module lcc_checker
  import lcc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_tready,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [TALLY_W-1:0] out_tdata,
  input wire logic               out_tuser,
  input wire logic               out_tlast
);

  // The input side only blocks while a result waits on a stalled receiver.
  `LCC_ASSERT_NOW(a_ready_only_on_stall, clk, rst_n, !in_tready, out_tvalid && !out_tready)

  // A hit always counts itself, so its run total is never zero.
  `LCC_ASSERT_NOW(a_hit_nonzero, clk, rst_n, out_tvalid && out_tuser, out_tdata != '0)

  // A stalled result holds its payload.
  `LCC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // No result is offered right after reset.
  `LCC_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_tvalid)

endmodule

bind lru_cache_hit_counter_top lcc_checker u_lcc_checker (.*);

`default_nettype wire
